// ===== hw/rtl/ffpa_pkg.sv =====
// ----------------------------------------------------------------------------
// ffpa_pkg: shared types and codes for the first-fit page allocator
// Request and response payload structs, status codes and a response builder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ffpa_pkg;

  localparam int ADDR_W  = 32;
  localparam int COUNT_W = 13;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_SPACE  = 2'd1;
  localparam logic [1:0] ST_ZERO_SIZE = 2'd2;
  localparam logic [1:0] ST_NOT_START = 2'd3;

  typedef struct packed {
    logic              req_type;
    logic [ADDR_W-1:0] size_bytes;
    logic [ADDR_W-1:0] free_address;
  } ffpa_req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [ADDR_W-1:0]  result_address;
    logic [COUNT_W-1:0] page_count;
  } ffpa_rsp_t;

  function automatic ffpa_rsp_t ffpa_mk_rsp(input logic [1:0] status,
                                            input logic [ADDR_W-1:0] addr,
                                            input logic [COUNT_W-1:0] count);
    ffpa_rsp_t rsp;
    rsp.status         = status;
    rsp.result_address = addr;
    rsp.page_count     = count;
    return rsp;
  endfunction

endpackage

// ===== hw/rtl/ffpa_ram.sv =====
// ----------------------------------------------------------------------------
// ffpa_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ffpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/first_fit_page_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// first_fit_page_allocator_unit: first-fit heap page allocator
// Page tags live in a RAM; allocate and free walk the tag table page by page.
// ----------------------------------------------------------------------------
// Usage:
//   Pulse start with a request on in_req while busy is low; the request is
//   taken on that edge. Allocate (req_type 0) rounds size_bytes up to pages
//   and claims the lowest free run that fits; free (req_type 1) releases the
//   allocation that starts at free_address.
//   One response appears on out_rsp for exactly one cycle with out_valid high;
//   the receiver cannot stall it. busy stays high until that cycle.
//   Allocate walks the tags from page 0 up to the end of the first run that
//   fits, then writes a tag to each of its pages; a failed allocate walks
//   all NUM_PAGES tags. Free walks and clears the tags of the released pages.
//   Zero size and out-of-range requests answer from idle without a walk. The
//   single read port of the tag RAM reads one tag per cycle.
//   After reset the unit clears the tag RAM one entry per cycle with busy
//   high; cfg writes to heap_base are taken at any time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module first_fit_page_allocator_unit #(
  parameter int NUM_PAGES = 4096,
  parameter int PAGE_BITS = 12
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  ffpa_pkg::ffpa_req_t in_req,
  output logic              out_valid,
  output ffpa_pkg::ffpa_rsp_t out_rsp,
  input  logic              cfg_we,
  input  logic [31:0]       cfg_wdata
);

  import ffpa_pkg::*;

  localparam int PW    = $clog2(NUM_PAGES);
  localparam int TAG_W = PW + 1;

  localparam logic [PW:0]       N_PAGES  = (PW + 1)'(NUM_PAGES);
  localparam logic [PW:0]       LAST_PG  = (PW + 1)'(NUM_PAGES - 1);
  localparam logic [ADDR_W:0]   PG_ROUND = (ADDR_W + 1)'((1 << PAGE_BITS) - 1);
  localparam logic [ADDR_W:0]   N_WIDE   = (ADDR_W + 1)'(NUM_PAGES);
  localparam logic [ADDR_W-1:0] N_ADDR   = ADDR_W'(NUM_PAGES);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_WR   = 3'd3;
  localparam logic [2:0] S_FREE = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [PW:0]       iss_r, iss_nxt;
  logic              pend_r, pend_nxt;
  logic [PW-1:0]     chk_r, chk_nxt;
  logic [PW:0]       run_r, run_nxt;
  logic [PW:0]       need_r, need_nxt;
  logic [PW-1:0]     first_r, first_nxt;
  logic [PW-1:0]     last_r, last_nxt;
  logic [PW-1:0]     sp_r, sp_nxt;
  logic [PW:0]       cnt_r, cnt_nxt;
  logic [ADDR_W-1:0] heap_base_r;
  logic              out_valid_r, out_valid_nxt;
  ffpa_rsp_t         rsp_r, rsp_nxt;

  logic              ram_we;
  logic [PW-1:0]     ram_waddr;
  logic [TAG_W-1:0]  ram_wdata;
  logic [PW-1:0]     ram_raddr;
  logic [TAG_W-1:0]  ram_rdata;

  logic              tag_valid;
  logic [PW-1:0]     tag_start;

  logic [ADDR_W:0]   need_full;
  logic [ADDR_W-1:0] free_off;
  logic [ADDR_W-1:0] free_pg;
  logic [PW:0]       first_full;

  assign tag_valid = ram_rdata[TAG_W-1];
  assign tag_start = ram_rdata[PW-1:0];

  assign need_full  = ({1'b0, in_req.size_bytes} + PG_ROUND) >> PAGE_BITS;
  assign free_off   = in_req.free_address - heap_base_r;
  assign free_pg    = free_off >> PAGE_BITS;
  assign first_full = {1'b0, chk_r} + (PW + 1)'(1) - need_r;

  ffpa_ram #(
    .WIDTH(TAG_W),
    .DEPTH(NUM_PAGES)
  ) u_tag_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    iss_nxt       = iss_r;
    pend_nxt      = pend_r;
    chk_nxt       = chk_r;
    run_nxt       = run_r;
    need_nxt      = need_r;
    first_nxt     = first_r;
    last_nxt      = last_r;
    sp_nxt        = sp_r;
    cnt_nxt       = cnt_r;
    rsp_nxt       = rsp_r;
    out_valid_nxt = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = iss_r[PW-1:0];
    ram_wdata     = '0;
    ram_raddr     = iss_r[PW-1:0];

    unique case (state_r)
      S_CLR: begin
        ram_we = 1'b1;
        if (iss_r == LAST_PG) begin
          iss_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          iss_nxt = iss_r + (PW + 1)'(1);
        end
      end

      S_IDLE: begin
        if (start) begin
          if (in_req.req_type == REQ_ALLOC) begin
            if (in_req.size_bytes == '0) begin
              rsp_nxt       = ffpa_mk_rsp(ST_ZERO_SIZE, '0, '0);
              out_valid_nxt = 1'b1;
            end else if (need_full > N_WIDE) begin
              rsp_nxt       = ffpa_mk_rsp(ST_NO_SPACE, '0, '0);
              out_valid_nxt = 1'b1;
            end else begin
              need_nxt  = need_full[PW:0];
              run_nxt   = '0;
              ram_raddr = '0;
              iss_nxt   = (PW + 1)'(1);
              pend_nxt  = 1'b1;
              chk_nxt   = '0;
              state_nxt = S_SCAN;
            end
          end else begin
            if (free_pg >= N_ADDR) begin
              rsp_nxt       = ffpa_mk_rsp(ST_NOT_START, '0, '0);
              out_valid_nxt = 1'b1;
            end else begin
              sp_nxt    = free_pg[PW-1:0];
              ram_raddr = free_pg[PW-1:0];
              iss_nxt   = free_pg[PW:0] + (PW + 1)'(1);
              pend_nxt  = 1'b1;
              chk_nxt   = free_pg[PW-1:0];
              cnt_nxt   = '0;
              state_nxt = S_FREE;
            end
          end
        end
      end

      S_SCAN: begin
        // read one tag ahead while checking the tag that just came back
        if (iss_r < N_PAGES) begin
          iss_nxt  = iss_r + (PW + 1)'(1);
          pend_nxt = 1'b1;
          chk_nxt  = iss_r[PW-1:0];
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r) begin
          if (tag_valid) begin
            run_nxt = '0;
          end else if (run_r + (PW + 1)'(1) == need_r) begin
            first_nxt = first_full[PW-1:0];
            last_nxt  = chk_r;
            iss_nxt   = {1'b0, first_full[PW-1:0]};
            state_nxt = S_WR;
          end else begin
            run_nxt = run_r + (PW + 1)'(1);
          end
        end else begin
          rsp_nxt       = ffpa_mk_rsp(ST_NO_SPACE, '0, '0);
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      S_WR: begin
        ram_we    = 1'b1;
        ram_wdata = {1'b1, first_r};
        if (iss_r[PW-1:0] == last_r) begin
          rsp_nxt = ffpa_mk_rsp(ST_OK,
                                heap_base_r + (ADDR_W'(first_r) << PAGE_BITS),
                                COUNT_W'(need_r));
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          iss_nxt = iss_r + (PW + 1)'(1);
        end
      end

      S_FREE: begin
        // clear the checked page while the next one is being read
        if (iss_r < N_PAGES) begin
          iss_nxt  = iss_r + (PW + 1)'(1);
          pend_nxt = 1'b1;
          chk_nxt  = iss_r[PW-1:0];
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r) begin
          if (tag_valid && tag_start == sp_r) begin
            ram_we    = 1'b1;
            ram_waddr = chk_r;
            ram_wdata = '0;
            cnt_nxt   = cnt_r + (PW + 1)'(1);
          end else begin
            if (cnt_r == '0) begin
              rsp_nxt = ffpa_mk_rsp(ST_NOT_START, '0, '0);
            end else begin
              rsp_nxt = ffpa_mk_rsp(ST_OK, '0, COUNT_W'(cnt_r));
            end
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end
        end else begin
          rsp_nxt       = ffpa_mk_rsp(ST_OK, '0, COUNT_W'(cnt_r));
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      iss_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      heap_base_r <= '0;
    end else begin
      state_r     <= state_nxt;
      iss_r       <= iss_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        heap_base_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    chk_r   <= chk_nxt;
    run_r   <= run_nxt;
    need_r  <= need_nxt;
    first_r <= first_nxt;
    last_r  <= last_nxt;
    sp_r    <= sp_nxt;
    cnt_r   <= cnt_nxt;
    rsp_r   <= rsp_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = rsp_r;

endmodule
